FILE: design/bcmp_pkg.sv
// Shared constants and handshake structs for the binomial coefficient block.
package bcmp_pkg;

  localparam int unsigned FIELD_W = 10;
  localparam int unsigned MOD_W = 30;
  localparam int unsigned MAX_N_DEFAULT = 1023;

  localparam logic [MOD_W-1:0] MODULUS = 30'd1000000007;

  // Barrett factor floor(2^(2*MOD_W) / MODULUS), fits in MOD_W+1 bits.
  localparam logic [63:0] MU_FULL = (64'd1 << (2 * MOD_W)) / {34'd0, MODULUS};
  localparam logic [MOD_W:0] BARRETT_MU = MU_FULL[MOD_W:0];

  // Quotient bits retired per divider cycle.
  localparam int unsigned DIV_DIGIT = 6;
  localparam int unsigned DIV_STEPS = MOD_W / DIV_DIGIT;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] a;
    logic [MOD_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] result;
  } mm_rsp_t;

  typedef struct packed {
    logic               done;
    logic [MOD_W-1:0]   quot;
    logic [FIELD_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: design/bcmp_req_if.sv
// Request channel carrying the set size and choose count.
interface bcmp_req_if;
  logic                         valid;
  logic                         ready;
  logic [bcmp_pkg::FIELD_W-1:0] set_size;
  logic [bcmp_pkg::FIELD_W-1:0] choose_count;

  modport source (output valid, output set_size, output choose_count, input ready);
  modport sink (input valid, input set_size, input choose_count, output ready);
endinterface

FILE: design/bcmp_rsp_if.sv
// Response channel carrying the coefficient.
interface bcmp_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bcmp_pkg::MOD_W-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink (input valid, input coefficient, output ready);
endinterface

FILE: design/bcmp_divider.sv
// Digit-serial divider of the modulus by a small divisor.
module bcmp_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bcmp_pkg::FIELD_W-1:0] divisor_i,
  output bcmp_pkg::div_rsp_t           rsp_o
);
  import bcmp_pkg::*;

  localparam int unsigned CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [FIELD_W-1:0]   div_q;
  logic [FIELD_W-1:0]   rem_q, rem_d;
  logic [MOD_W-1:0]     dvd_q;
  logic [MOD_W-1:0]     quot_q, quot_d;

  // Retire DIV_DIGIT restoring steps per cycle.
  always_comb begin
    logic [FIELD_W:0]     trial;
    logic [FIELD_W-1:0]   r;
    logic [DIV_DIGIT-1:0] digit;
    r = rem_q;
    digit = '0;
    for (int j = 0; j < DIV_DIGIT; j++) begin
      trial = {r, dvd_q[MOD_W-1-j]};
      if (trial >= {1'b0, div_q}) begin
        r = FIELD_W'(trial - {1'b0, div_q});
        digit[DIV_DIGIT-1-j] = 1'b1;
      end else begin
        r = trial[FIELD_W-1:0];
      end
    end
    rem_d = r;
    quot_d = {quot_q[MOD_W-DIV_DIGIT-1:0], digit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      div_q  <= divisor_i;
      rem_q  <= '0;
      dvd_q  <= MODULUS;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
      dvd_q  <= dvd_q << DIV_DIGIT;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: design/bcmp_mulmod.sv
// Modular multiplier: one shared multiplier, Barrett reduction, serial correction.
module bcmp_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcmp_pkg::mm_req_t req_i,
  output bcmp_pkg::mm_rsp_t rsp_o
);
  import bcmp_pkg::*;

  localparam logic [2:0] MM_IDLE = 3'd0;
  localparam logic [2:0] MM_MUL1 = 3'd1;
  localparam logic [2:0] MM_MUL2 = 3'd2;
  localparam logic [2:0] MM_MUL3 = 3'd3;
  localparam logic [2:0] MM_CORR = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [MOD_W-1:0]     a_q, b_q;
  logic [2*MOD_W-1:0]   x_q;
  logic [MOD_W:0]       q3_q;
  logic [MOD_W+1:0]     r_q;
  logic [MOD_W:0]       op_a, op_b;
  logic [2*MOD_W+1:0]   prod;
  logic                 corr_done;

  // Route the operands of the single multiplier by phase.
  always_comb begin
    case (state_q)
      MM_MUL1: begin
        op_a = {1'b0, a_q};
        op_b = {1'b0, b_q};
      end
      MM_MUL2: begin
        op_a = x_q[2*MOD_W-1:MOD_W-1];
        op_b = BARRETT_MU;
      end
      MM_MUL3: begin
        op_a = q3_q;
        op_b = {1'b0, MODULUS};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;
  assign corr_done = (state_q == MM_CORR) && (r_q < {2'b00, MODULUS});

  always_comb begin
    state_d = state_q;
    case (state_q)
      MM_IDLE: if (req_i.start) state_d = MM_MUL1;
      MM_MUL1: state_d = MM_MUL2;
      MM_MUL2: state_d = MM_MUL3;
      MM_MUL3: state_d = MM_CORR;
      MM_CORR: if (corr_done) state_d = MM_IDLE;
      default: state_d = MM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MM_IDLE: begin
        if (req_i.start) begin
          a_q <= req_i.a;
          b_q <= req_i.b;
        end
      end
      MM_MUL1: x_q <= prod[2*MOD_W-1:0];
      MM_MUL2: q3_q <= prod[2*MOD_W+1:MOD_W+1];
      // Barrett leaves the remainder below three moduli, so 32 low bits suffice.
      MM_MUL3: r_q <= x_q[MOD_W+1:0] - prod[MOD_W+1:0];
      MM_CORR: if (!corr_done) r_q <= r_q - {2'b00, MODULUS};
      default: ;
    endcase
  end

  assign rsp_o.busy   = (state_q != MM_IDLE);
  assign rsp_o.done   = corr_done;
  assign rsp_o.result = r_q[MOD_W-1:0];

endmodule

FILE: design/binomial_coefficient_mod_prime.sv
// Top level: sequencer, inverse table and output register for C(n, r) mod 1000000007.
//
//   channel  dir  payload                    accepted when
//   req_i    in   set_size, choose_count     req_i.valid && req_i.ready
//   rsp_o    out  coefficient                rsp_o.valid && rsp_o.ready
//
// Sequence: an item with r > n, r = 0 or n > MAX_N goes straight from accept to
//   finish; otherwise the first unit of r takes one step state and one product,
//   and each further unit takes a step state, a divider run and three modular
//   products on the shared multiplier.
// req_i.ready is high only while the sequencer idles; one item at a time.
// Reset clears the sequencer and output valid; the inverse table is not cleared,
//   every entry is written before it is read within the same item.
// A result held by a stalled rsp_o does not block the next request; the sequencer
//   waits at its end only if the output register is still occupied.
module binomial_coefficient_mod_prime #(
  parameter int unsigned MAX_N = bcmp_pkg::MAX_N_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcmp_req_if.sink   req_i,
  bcmp_rsp_if.source rsp_o
);
  import bcmp_pkg::*;

  localparam int unsigned DEPTH = MAX_N + 1;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] MAX_N_U = 32'(MAX_N);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_STEP     = 4'd1;
  localparam logic [3:0] S_DIV      = 4'd2;
  localparam logic [3:0] S_INV_MUL  = 4'd3;
  localparam logic [3:0] S_INV_WAIT = 4'd4;
  localparam logic [3:0] S_ACC_MUL  = 4'd5;
  localparam logic [3:0] S_ACC_WAIT = 4'd6;
  localparam logic [3:0] S_N_MUL    = 4'd7;
  localparam logic [3:0] S_N_WAIT   = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [FIELD_W-1:0] n_q, r_q, i_q;
  logic [MOD_W-1:0]   acc_q, inv_q, coef_q;
  logic               out_valid_q;

  logic               req_fire, rsp_fire, out_load;
  logic               trivial;
  logic [MOD_W-1:0]   inv_val;

  logic [MOD_W-1:0]   inv_mem [DEPTH];
  logic [MOD_W-1:0]   rd_data_q;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [MOD_W-1:0]   mem_wdata;

  logic               div_start;
  div_rsp_t           div_rsp;
  mm_req_t            mm_req;
  mm_rsp_t            mm_rsp;

  bcmp_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (i_q),
    .rsp_o     (div_rsp)
  );

  bcmp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign out_load    = (state_q == S_FINISH) && (!out_valid_q || rsp_o.ready);

  // Out-of-range and empty selections skip the table altogether.
  assign trivial = (req_i.choose_count > req_i.set_size)
                || (32'(req_i.set_size) > MAX_N_U)
                || (req_i.choose_count == '0);

  // Negate the product: inv[i] = (M - t) mod M.
  assign inv_val = (mm_rsp.result == '0) ? '0 : (MODULUS - mm_rsp.result);

  assign div_start = (state_q == S_STEP) && (i_q != FIELD_W'(1));

  // Feed the shared multiplier from the phase of the sequencer.
  always_comb begin
    mm_req.start = 1'b0;
    mm_req.a     = acc_q;
    mm_req.b     = inv_q;
    case (state_q)
      S_INV_MUL: begin
        mm_req.start = 1'b1;
        mm_req.a     = div_rsp.quot;
        mm_req.b     = rd_data_q;
      end
      S_ACC_MUL: begin
        mm_req.start = 1'b1;
      end
      S_N_MUL: begin
        mm_req.start = 1'b1;
        mm_req.b     = MOD_W'(n_q - i_q + FIELD_W'(1));
      end
      default: ;
    endcase
  end

  // Table port control: seed inv[1], write each new inverse, read inv[M mod i].
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(i_q);
    mem_wdata = inv_val;
    mem_re    = (state_q == S_DIV) && div_rsp.done;
    mem_raddr = IDX_W'(div_rsp.rem);
    if ((state_q == S_STEP) && (i_q == FIELD_W'(1))) begin
      mem_we    = 1'b1;
      mem_wdata = MOD_W'(1);
    end else if ((state_q == S_INV_WAIT) && mm_rsp.done) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) inv_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= inv_mem[mem_raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) state_d = trivial ? S_FINISH : S_STEP;
      end
      S_STEP:     state_d = (i_q == FIELD_W'(1)) ? S_N_MUL : S_DIV;
      S_DIV:      if (div_rsp.done) state_d = S_INV_MUL;
      S_INV_MUL:  state_d = S_INV_WAIT;
      S_INV_WAIT: if (mm_rsp.done) state_d = S_ACC_MUL;
      S_ACC_MUL:  state_d = S_ACC_WAIT;
      S_ACC_WAIT: if (mm_rsp.done) state_d = S_N_MUL;
      S_N_MUL:    state_d = S_N_WAIT;
      S_N_WAIT: begin
        if (mm_rsp.done) state_d = (i_q == r_q) ? S_FINISH : S_STEP;
      end
      S_FINISH:   if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers; the products are accumulated into acc_q, mod M.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      n_q <= req_i.set_size;
      r_q <= req_i.choose_count;
      i_q <= FIELD_W'(1);
      if ((req_i.choose_count > req_i.set_size) || (32'(req_i.set_size) > MAX_N_U)) begin
        acc_q <= '0;
      end else begin
        acc_q <= MOD_W'(1);
      end
    end
    if ((state_q == S_INV_WAIT) && mm_rsp.done) inv_q <= inv_val;
    if ((state_q == S_ACC_WAIT) && mm_rsp.done) acc_q <= mm_rsp.result;
    if ((state_q == S_N_WAIT) && mm_rsp.done) begin
      acc_q <= mm_rsp.result;
      i_q   <= i_q + FIELD_W'(1);
    end
    if (out_load) coef_q <= acc_q;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.coefficient = coef_q;

  // Hold the loop counter inside 1..r while the table is in use.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_FINISH) |-> (i_q != '0 && i_q <= r_q))
    else $error("loop index left 1..r");

  // Start the multiplier only when it has returned to idle.
  a_mm_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  // Drop ready for the cycle after a request transaction.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready)
    else $error("request accepted twice in a row");

  // Keep every reduced product and every delivered result below the modulus.
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mm_rsp.done |-> mm_rsp.result < MODULUS) and
    (rsp_o.valid |-> rsp_o.coefficient < MODULUS))
    else $error("value not reduced modulo M");

endmodule
